// ----- rtl/core/rgbled_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and the brightness table of the LED strip encoder.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    localparam int LEDS_PER_STRIP = 64;
    localparam int RESET_SLOTS    = 50;
    localparam int BITS_PER_LED   = 24;
    localparam int MAX_LEVEL      = 20;

    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 3 * CHAN_W;
    localparam int DUTY_W     = 16;
    localparam int FACTOR_W   = 16;
    localparam int LEVEL_W    = 8;
    localparam int LVL_IDX_W  = $clog2(MAX_LEVEL + 1);
    localparam int LED_IDX_W  = 6;
    localparam int ADDR_W     = LED_IDX_W + 1;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int ACC_W      = CHAN_W + FACTOR_W;
    localparam int STEP_W     = $clog2(CHAN_W);
    localparam int MAX_SLOTS  = (RESET_SLOTS > BITS_PER_LED) ? RESET_SLOTS : BITS_PER_LED;
    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [2:0] {
        CMD_SET_COLOUR     = 3'd0,
        CMD_SET_BRIGHTNESS = 3'd1,
        CMD_CLEAR_COLOURS  = 3'd2,
        CMD_EMIT_RESET     = 3'd3,
        CMD_EMIT_LED       = 3'd4
    } rgbled_cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_EN  = 2'd2;

    localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 16'd60;
    localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 16'd30;

    typedef struct packed {
        logic                raw_we;
        logic                scaled_we;
        logic                raw_clear;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] data;
    } rgbled_wr_t;

    typedef struct packed {
        logic                valid;
        logic                is_reset;
        logic [COLOUR_W-1:0] colour;
    } rgbled_load_t;

    function automatic logic [FACTOR_W-1:0] tan_factor(input logic [LVL_IDX_W-1:0] lvl);
        logic [FACTOR_W-1:0] f;
        unique case (lvl)
            5'd1:    f = 16'd1144;
            5'd2:    f = 16'd2289;
            5'd3:    f = 16'd3435;
            5'd4:    f = 16'd4583;
            5'd5:    f = 16'd5734;
            5'd6:    f = 16'd6888;
            5'd7:    f = 16'd8047;
            5'd8:    f = 16'd9210;
            5'd9:    f = 16'd10380;
            5'd10:   f = 16'd11556;
            5'd11:   f = 16'd12739;
            5'd12:   f = 16'd13930;
            5'd13:   f = 16'd15130;
            5'd14:   f = 16'd16340;
            5'd15:   f = 16'd17560;
            5'd16:   f = 16'd18792;
            5'd17:   f = 16'd20036;
            5'd18:   f = 16'd21294;
            5'd19:   f = 16'd22566;
            5'd20:   f = 16'd23853;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/rgbled_store.sv -----
// ----------------------------------------------------------------------------
// rgbled_store
// Raw and scaled colour memories for both strips, with per-entry valid bits.
// ----------------------------------------------------------------------------
module rgbled_store
    import rgbled_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  rgbled_wr_t          wr,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [COLOUR_W-1:0] raw_colour,
    output logic [COLOUR_W-1:0] scaled_colour
);

    logic [COLOUR_W-1:0]  raw_mem    [MEM_DEPTH];
    logic [COLOUR_W-1:0]  scaled_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] raw_vld_reg;
    logic [MEM_DEPTH-1:0] scaled_vld_reg;
    logic [COLOUR_W-1:0]  raw_rd_reg;
    logic [COLOUR_W-1:0]  scaled_rd_reg;
    logic                 raw_rd_vld_reg;
    logic                 scaled_rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.raw_we) begin
            raw_mem[wr.addr] <= wr.data;
        end
        if (wr.scaled_we) begin
            scaled_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            raw_rd_reg    <= raw_mem[rd_addr];
            scaled_rd_reg <= scaled_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_vld_reg       <= '0;
            scaled_vld_reg    <= '0;
            raw_rd_vld_reg    <= 1'b0;
            scaled_rd_vld_reg <= 1'b0;
        end else begin
            if (wr.raw_clear) begin
                raw_vld_reg <= '0;
            end else if (wr.raw_we) begin
                raw_vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.scaled_we) begin
                scaled_vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                raw_rd_vld_reg    <= raw_vld_reg[rd_addr];
                scaled_rd_vld_reg <= scaled_vld_reg[rd_addr];
            end
        end
    end

    assign raw_colour    = raw_rd_vld_reg    ? raw_rd_reg    : '0;
    assign scaled_colour = scaled_rd_vld_reg ? scaled_rd_reg : '0;

endmodule

// ----- rtl/core/rgbled_scaler.sv -----
// ----------------------------------------------------------------------------
// rgbled_scaler
// Bit-serial shift-and-add scaling of the three colour channels by a factor.
// ----------------------------------------------------------------------------
module rgbled_scaler
    import rgbled_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [COLOUR_W-1:0] colour,
    input  logic [FACTOR_W-1:0] factor,
    output logic                done,
    output logic [COLOUR_W-1:0] result
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COLOUR_W-1:0] bits_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [ACC_W-1:0]    acc_reg  [3];
    logic [ACC_W-1:0]    acc_next [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc_next[ch] = {acc_reg[ch][ACC_W-2:0], 1'b0}
                         + (bits_reg[CHAN_W*ch + CHAN_W - 1] ? ACC_W'(factor_reg) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CHAN_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bits_reg   <= colour;
            factor_reg <= factor;
            for (int ch = 0; ch < 3; ch++) begin
                acc_reg[ch] <= '0;
            end
        end else if (busy_reg) begin
            bits_reg <= {bits_reg[COLOUR_W-2:0], 1'b0};
            for (int ch = 0; ch < 3; ch++) begin
                acc_reg[ch] <= acc_next[ch];
            end
        end
    end

    assign done   = done_reg;
    assign result = {acc_reg[2][ACC_W-1:FACTOR_W], acc_reg[1][ACC_W-1:FACTOR_W],
                     acc_reg[0][ACC_W-1:FACTOR_W]};

endmodule

// ----- rtl/core/rgbled_serialiser.sv -----
// ----------------------------------------------------------------------------
// rgbled_serialiser
// Shifts a colour out MSB first as duty beats, or sends the zero reset slots.
// ----------------------------------------------------------------------------
module rgbled_serialiser
    import rgbled_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  rgbled_load_t        load,
    input  logic [DUTY_W-1:0]   duty_one,
    input  logic [DUTY_W-1:0]   duty_zero,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DUTY_W-1:0]   m_duty,
    output logic                m_last
);

    logic [COLOUR_W-1:0]   shift_reg;
    logic                  reset_mode_reg;
    logic [SLOT_CNT_W-1:0] remain_reg;
    logic                  m_valid_reg;
    logic [DUTY_W-1:0]     m_duty_reg;
    logic                  m_last_reg;
    logic                  advance;

    assign advance = (remain_reg != '0) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load.valid) begin
                remain_reg <= load.is_reset ? SLOT_CNT_W'(RESET_SLOTS)
                                            : SLOT_CNT_W'(BITS_PER_LED);
            end else if (advance) begin
                remain_reg <= remain_reg - 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            shift_reg      <= load.colour;
            reset_mode_reg <= load.is_reset;
        end else if (advance) begin
            shift_reg <= {shift_reg[COLOUR_W-2:0], 1'b0};
        end
        if (advance) begin
            m_duty_reg <= reset_mode_reg ? '0
                        : (shift_reg[COLOUR_W-1] ? duty_one : duty_zero);
            m_last_reg <= (remain_reg == SLOT_CNT_W'(1));
        end
    end

    assign busy    = (remain_reg != '0) || m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_duty  = m_duty_reg;
    assign m_last  = m_last_reg;

endmodule

// ----- rtl/core/rgb_led_strip_pwm_encoder_core.sv -----
// ----------------------------------------------------------------------------
// rgb_led_strip_pwm_encoder_core
// Two-strip colour store with brightness scaling and a PWM duty bit encoder.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  command | s_valid/s_ready, s_* fields    | in
//  slots   | m_valid/m_ready, m_duty/m_last | out
//  regs    | cfg_we, cfg_index, cfg_wdata   | in
//
//  set colour and clear colours write the store when taken; set brightness does
//  one memory read, one scaler load, eight shift-and-add steps and one write.
//  emit led passes ST_LOAD, the serialiser load and the output register, then
//  one beat per cycle unless stalled (24 beats); emit reset skips ST_LOAD (50 beats)
//  the output register holds a beat under stall; s_ready stays low until the
//  last beat of a command is taken. reset clears all colours via valid bits
// ----------------------------------------------------------------------------
module rgb_led_strip_pwm_encoder_core
    import rgbled_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_command,
    input  logic                 s_strip,
    input  logic [LED_IDX_W-1:0] s_led_index,
    input  logic [CHAN_W-1:0]    s_red,
    input  logic [CHAN_W-1:0]    s_green,
    input  logic [CHAN_W-1:0]    s_blue,
    input  logic [LEVEL_W-1:0]   s_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_W-1:0]    m_duty,
    output logic                 m_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_SCALE,
        ST_SCALE,
        ST_LOAD
    } state_t;

    state_t              state_reg;
    logic [DUTY_W-1:0]   duty_one_reg;
    logic [DUTY_W-1:0]   duty_zero_reg;
    logic                bright_en_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                ok_reg;

    rgbled_cmd_t          cmd;
    logic                 accept;
    logic                 idx_ok;
    logic [ADDR_W-1:0]    in_addr;
    logic [LVL_IDX_W-1:0] lvl_clamped;
    rgbled_wr_t           wr;
    rgbled_load_t         load;
    logic                 ser_busy;
    logic [COLOUR_W-1:0]  raw_colour;
    logic [COLOUR_W-1:0]  scaled_colour;
    logic                 scale_done;
    logic [COLOUR_W-1:0]  scale_result;

    assign cmd         = rgbled_cmd_t'(s_command);
    assign s_ready     = (state_reg == ST_IDLE) && !ser_busy;
    assign accept      = s_valid && s_ready;
    assign idx_ok      = int'(s_led_index) < LEDS_PER_STRIP;
    assign in_addr     = {s_strip, s_led_index};
    assign lvl_clamped = (s_level > LEVEL_W'(MAX_LEVEL)) ? LVL_IDX_W'(MAX_LEVEL)
                                                        : s_level[LVL_IDX_W-1:0];

    always_comb begin
        wr.raw_we    = accept && (cmd == CMD_SET_COLOUR) && idx_ok;
        wr.raw_clear = accept && (cmd == CMD_CLEAR_COLOURS);
        wr.scaled_we = (state_reg == ST_SCALE) && scale_done;
        wr.addr      = wr.scaled_we ? addr_reg : in_addr;
        wr.data      = wr.scaled_we ? scale_result : {s_green, s_red, s_blue};

        load.valid    = (accept && (cmd == CMD_EMIT_RESET)) || (state_reg == ST_LOAD);
        load.is_reset = (state_reg != ST_LOAD);
        load.colour   = ok_reg ? (bright_en_reg ? scaled_colour : raw_colour) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            duty_one_reg  <= DUTY_ONE_RST;
            duty_zero_reg <= DUTY_ZERO_RST;
            bright_en_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DUTY_ONE:  duty_one_reg  <= cfg_wdata;
                    REG_DUTY_ZERO: duty_zero_reg <= cfg_wdata;
                    REG_BRIGHT_EN: bright_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (cmd == CMD_SET_BRIGHTNESS) && idx_ok) begin
                        state_reg <= ST_READ_SCALE;
                    end else if (accept && (cmd == CMD_EMIT_LED)) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_READ_SCALE: state_reg <= ST_SCALE;
                ST_SCALE: begin
                    if (scale_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LOAD: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg   <= in_addr;
            factor_reg <= tan_factor(lvl_clamped);
            ok_reg     <= idx_ok;
        end
    end

    rgbled_store u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr            (wr),
        .rd_en         (accept),
        .rd_addr       (in_addr),
        .raw_colour    (raw_colour),
        .scaled_colour (scaled_colour)
    );

    rgbled_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_READ_SCALE),
        .colour  (raw_colour),
        .factor  (factor_reg),
        .done    (scale_done),
        .result  (scale_result)
    );

    rgbled_serialiser u_serialiser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .duty_one  (duty_one_reg),
        .duty_zero (duty_zero_reg),
        .busy      (ser_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_duty    (m_duty),
        .m_last    (m_last)
    );

endmodule

// ----- rtl/core/rgbled_checker.sv -----
// ----------------------------------------------------------------------------
// rgbled_checker
// Port-level checks on the LED strip encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rgbled_checker
    import rgbled_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [2:0]           s_command,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [DUTY_W-1:0]    m_duty,
    input  logic                 m_last
);

    // no new command while a beat is pending
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("command taken while a beat is pending");

    a_reset_slots_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_EMIT_RESET)) |-> ##2 m_valid)
        else $error("reset slots did not start");

    a_led_slots_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_EMIT_LED)) |-> ##3 m_valid)
        else $error("led slots did not start");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("not ready after final beat");

    a_beat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_duty) && $stable(m_last)))
        else $error("stalled beat changed");

endmodule

bind rgb_led_strip_pwm_encoder_core rgbled_checker u_rgbled_checker (.*);

// ----- bench/rgb_led_strip_pwm_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// rgb_led_strip_pwm_encoder_checker
// Watches the command, slot and register ports of the LED strip encoder and
// keeps its own copy of both colour stores and of the registers. Every command
// beat is turned into the duty slots it must produce, and every slot beat is
// compared with the oldest slot still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_strip_pwm_encoder_checker
    import rgbled_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [2:0]           s_command,
    input  logic                 s_strip,
    input  logic [LED_IDX_W-1:0] s_led_index,
    input  logic [CHAN_W-1:0]    s_red,
    input  logic [CHAN_W-1:0]    s_green,
    input  logic [CHAN_W-1:0]    s_blue,
    input  logic [LEVEL_W-1:0]   s_level,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [DUTY_W-1:0]    m_duty,
    input  logic                 m_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_wdata,
    input  logic                 end_of_run,
    output int unsigned          mismatches,
    output int unsigned          slots_waiting,
    output int unsigned          slots_checked
);

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } duty_slot_t;

    // tan(level degrees) in unsigned q0.16
    logic [15:0] tan_q16_lut [0:20] = '{
        16'd0,     16'd1144,  16'd2289,  16'd3435,  16'd4583,  16'd5734,  16'd6888,
        16'd8047,  16'd9210,  16'd10380, 16'd11556, 16'd12739, 16'd13930, 16'd15130,
        16'd16340, 16'd17560, 16'd18792, 16'd20036, 16'd21294, 16'd22566, 16'd23853
    };

    logic [COLOUR_W-1:0] raw_grb    [2][LEDS_PER_STRIP];
    logic [COLOUR_W-1:0] scaled_grb [2][LEDS_PER_STRIP];
    logic [DUTY_W-1:0]   duty_one_q;
    logic [DUTY_W-1:0]   duty_zero_q;
    logic                bright_en_q;
    duty_slot_t          expected_slots [$];

    initial begin
        mismatches    = 0;
        slots_waiting = 0;
        slots_checked = 0;
    end

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [15:0] f);
        logic [23:0] prod;
        prod = c * f;
        return prod[23:16];
    endfunction

    task automatic predict_slots();
        logic [COLOUR_W-1:0] c;
        logic [15:0]         f;
        logic [LEVEL_W-1:0]  lvl;
        duty_slot_t          slot;
        case (s_command)
            CMD_SET_COLOUR: begin
                raw_grb[s_strip][s_led_index] = {s_green, s_red, s_blue};
            end
            CMD_SET_BRIGHTNESS: begin
                lvl = (s_level > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : s_level;
                f   = tan_q16_lut[lvl];
                c   = raw_grb[s_strip][s_led_index];
                scaled_grb[s_strip][s_led_index] =
                    {scale_chan(c[23:16], f), scale_chan(c[15:8], f), scale_chan(c[7:0], f)};
            end
            CMD_CLEAR_COLOURS: begin
                for (int s = 0; s < 2; s++)
                    for (int i = 0; i < LEDS_PER_STRIP; i++)
                        raw_grb[s][i] = '0;
            end
            CMD_EMIT_RESET: begin
                for (int n = 0; n < RESET_SLOTS; n++) begin
                    slot.duty = '0;
                    slot.last = (n == RESET_SLOTS - 1);
                    expected_slots.push_back(slot);
                end
            end
            CMD_EMIT_LED: begin
                c = bright_en_q ? scaled_grb[s_strip][s_led_index]
                                : raw_grb[s_strip][s_led_index];
                for (int n = 0; n < BITS_PER_LED; n++) begin
                    slot.duty = c[BITS_PER_LED - 1 - n] ? duty_one_q : duty_zero_q;
                    slot.last = (n == BITS_PER_LED - 1);
                    expected_slots.push_back(slot);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        duty_slot_t want;
        if (!aresetn) begin
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < LEDS_PER_STRIP; i++) begin
                    raw_grb[s][i]    = '0;
                    scaled_grb[s][i] = '0;
                end
            duty_one_q  = DUTY_ONE_RST;
            duty_zero_q = DUTY_ZERO_RST;
            bright_en_q = 1'b1;
            expected_slots.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DUTY_ONE:  duty_one_q  = cfg_wdata;
                    REG_DUTY_ZERO: duty_zero_q = cfg_wdata;
                    REG_BRIGHT_EN: bright_en_q = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_slots.size() == 0) begin
                    report("slot beat with nothing owed, duty", 0, 32'(m_duty));
                end else begin
                    want = expected_slots.pop_front();
                    slots_checked++;
                    if (m_duty !== want.duty)
                        report("slot duty", 32'(want.duty), 32'(m_duty));
                    if (m_last !== want.last)
                        report("slot last flag", 32'(want.last), 32'(m_last));
                end
            end
            if (s_valid && s_ready)
                predict_slots();
        end
        slots_waiting = expected_slots.size();
    end

    always @(posedge end_of_run) begin
        duty_slot_t gone;
        while (expected_slots.size() != 0) begin
            gone = expected_slots.pop_front();
            report("slot never delivered, duty", 32'(gone.duty), 0);
        end
        slots_waiting = 0;
    end

endmodule

// ----- bench/tb_rgb_led_strip_pwm_encoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_pwm_encoder_core
// Drives directed and random command streams into the LED strip encoder under
// several duty and brightness settings, with bursty commands and a stalling
// slot receiver; the checker beside the block predicts and compares slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_led_strip_pwm_encoder_core;
    import rgbled_pkg::*;

    localparam int SETTLE     = 24;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_CMDS = 98;

    localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;
    localparam logic [2:0] LAST_UNUSED_CMD  = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [2:0]           s_command;
    logic                 s_strip;
    logic [LED_IDX_W-1:0] s_led_index;
    logic [CHAN_W-1:0]    s_red;
    logic [CHAN_W-1:0]    s_green;
    logic [CHAN_W-1:0]    s_blue;
    logic [LEVEL_W-1:0]   s_level;
    logic                 m_valid;
    logic                 m_ready;
    logic [DUTY_W-1:0]    m_duty;
    logic                 m_last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUTY_W-1:0]    cfg_wdata;
    logic                 end_of_run;

    int unsigned mismatches;
    int unsigned slots_waiting;
    int unsigned slots_checked;
    int unsigned cmd_count [8];
    int unsigned settings_run;
    int          burst_left;
    int          idle_cycles;

    rgb_led_strip_pwm_encoder_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_strip     (s_strip),
        .s_led_index (s_led_index),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_level     (s_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty      (m_duty),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    rgb_led_strip_pwm_encoder_checker slot_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_strip       (s_strip),
        .s_led_index   (s_led_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_level       (s_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_last        (m_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .end_of_run    (end_of_run),
        .mismatches    (mismatches),
        .slots_waiting (slots_waiting),
        .slots_checked (slots_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // slot receiver stalls in runs of differing density
    initial begin
        int stall_mode;
        int run_len;
        m_ready = 1'b0;
        forever begin
            stall_mode = $urandom_range(0, 3);
            run_len    = $urandom_range(8, 60);
            repeat (run_len) begin
                @(negedge aclk);
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d slots owed",
                     IDLE_LIMIT, slots_waiting);
            $display("rgb_led_strip_pwm_encoder_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [2:0] cmd, input logic strip,
                        input logic [LED_IDX_W-1:0] idx, input logic [CHAN_W-1:0] r,
                        input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                        input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_strip     <= strip;
        s_led_index <= idx;
        s_red       <= r;
        s_green     <= g;
        s_blue      <= b;
        s_level     <= lvl;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        cmd_count[cmd]++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (slots_waiting != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [DUTY_W-1:0] one, input logic [DUTY_W-1:0] zero,
                              input logic en);
        logic [DUTY_W-1:0] noise;
        wait_idle();
        noise = DUTY_W'($urandom_range(0, 65535));
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DUTY_ONE;
        cfg_wdata <= one;
        @(negedge aclk);
        cfg_index <= REG_DUTY_ZERO;
        cfg_wdata <= zero;
        @(negedge aclk);
        cfg_index <= REG_BRIGHT_EN;
        cfg_wdata <= {noise[DUTY_W-1:1], en};
        @(negedge aclk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [LED_IDX_W-1:0] pick_led();
        return ($urandom_range(0, 3) == 0) ? LED_IDX_W'($urandom_range(0, LEDS_PER_STRIP - 1))
                                           : LED_IDX_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        return ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(0, 255))
                                           : LEVEL_W'($urandom_range(0, MAX_LEVEL));
    endfunction

    // returns the number of commands that count toward the phase
    task automatic random_step(output int counted);
        logic                 strip;
        logic [LED_IDX_W-1:0] idx;
        int                   pick;
        strip = 1'($urandom_range(0, 1));
        idx   = pick_led();
        pick  = $urandom_range(0, 99);
        counted = 1;
        if (pick < 50) begin
            send(CMD_SET_COLOUR, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
            send(CMD_SET_BRIGHTNESS, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), pick_level());
            send(CMD_EMIT_LED, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
            counted = 3;
        end else if (pick < 62) begin
            send(CMD_SET_COLOUR, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
        end else if (pick < 72) begin
            send(CMD_SET_BRIGHTNESS, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), pick_level());
        end else if (pick < 88) begin
            send(CMD_EMIT_LED, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
        end else if (pick < 92) begin
            send(CMD_EMIT_RESET, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
        end else if (pick < 94) begin
            send(CMD_CLEAR_COLOURS, strip, idx, rand_byte(),
                 rand_byte(), rand_byte(), rand_byte());
        end else begin
            send(3'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD)), strip, idx,
                 rand_byte(), rand_byte(), rand_byte(), rand_byte());
            counted = 0;
        end
    endtask

    task automatic random_phase();
        int done;
        int step;
        done = 0;
        while (done < PHASE_CMDS) begin
            random_step(step);
            done += step;
        end
    endtask

    initial begin
        int total;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_SET_COLOUR;
        s_strip      = 1'b0;
        s_led_index  = '0;
        s_red        = '0;
        s_green      = '0;
        s_blue       = '0;
        s_level      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_DUTY_ONE;
        cfg_wdata    = '0;
        end_of_run   = 1'b0;
        burst_left   = 0;
        idle_cycles  = 0;
        settings_run = 1;
        foreach (cmd_count[i]) cmd_count[i] = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at reset register values
        send(CMD_EMIT_LED,       1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_EMIT_RESET,     1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_COLOUR,     1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send(CMD_SET_COLOUR,     1'b0, 6'd0,  8'hA5, 8'h3C, 8'h81, 8'd0);
        send(CMD_EMIT_LED,       1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_BRIGHTNESS, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd20);
        send(CMD_EMIT_LED,       1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_BRIGHTNESS, 1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd255);
        send(CMD_EMIT_LED,       1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_BRIGHTNESS, 1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_EMIT_LED,       1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_BRIGHTNESS, 1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd21);
        send(CMD_CLEAR_COLOURS,  1'b0, 6'd0,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_EMIT_LED,       1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd0);
        for (int c = FIRST_UNUSED_CMD; c <= LAST_UNUSED_CMD; c++)
            send(c[2:0], 1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send(CMD_EMIT_RESET,     1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // raw colours out at duty extremes, then scaled colours at reset duty values
        write_regs(16'hFFFF, 16'h0000, 1'b0);
        send(CMD_EMIT_LED,       1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_COLOUR,     1'b1, 6'd5,  8'hFF, 8'h00, 8'hFF, 8'd0);
        send(CMD_EMIT_LED,       1'b1, 6'd5,  8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_SET_BRIGHTNESS, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd10);
        write_regs(DUTY_ONE_RST, DUTY_ZERO_RST, 1'b1);
        send(CMD_EMIT_LED,       1'b1, 6'd63, 8'h00, 8'h00, 8'h00, 8'd0);
        send(CMD_EMIT_LED,       1'b1, 6'd5,  8'h00, 8'h00, 8'h00, 8'd0);

        // random part over four register settings
        write_regs(16'hFFFF, 16'h0000, 1'b1);
        random_phase();
        write_regs(16'h0000, 16'hFFFF, 1'b0);
        random_phase();
        write_regs(DUTY_W'($urandom_range(0, 65535)), DUTY_W'($urandom_range(0, 65535)), 1'b1);
        random_phase();
        write_regs(DUTY_W'($urandom_range(0, 65535)), DUTY_W'($urandom_range(0, 65535)), 1'b0);
        random_phase();

        wait_idle();
        end_of_run <= 1'b1;
        repeat (2) @(negedge aclk);

        total = 0;
        foreach (cmd_count[i]) total += cmd_count[i];
        $display("run covered %0d commands: %0d colour writes, %0d brightness, %0d clears,",
                 total, cmd_count[CMD_SET_COLOUR], cmd_count[CMD_SET_BRIGHTNESS],
                 cmd_count[CMD_CLEAR_COLOURS]);
        $display("  %0d reset emits, %0d led emits, %0d unused codes; %0d slots over %0d settings",
                 cmd_count[CMD_EMIT_RESET], cmd_count[CMD_EMIT_LED],
                 total - cmd_count[CMD_SET_COLOUR] - cmd_count[CMD_SET_BRIGHTNESS]
                       - cmd_count[CMD_CLEAR_COLOURS] - cmd_count[CMD_EMIT_RESET]
                       - cmd_count[CMD_EMIT_LED],
                 slots_checked, settings_run);
        if (mismatches == 0) begin
            $display("rgb_led_strip_pwm_encoder_core: match");
        end else begin
            $display("rgb_led_strip_pwm_encoder_core: mismatch");
        end
        $finish;
    end

endmodule
